/* rtl/symbolic_file_mode_parser_unit_macros.svh */
// Assertion macros shared by the checker of the mode parser.
`ifndef SYMBOLIC_FILE_MODE_PARSER_UNIT_MACROS_SVH
`define SYMBOLIC_FILE_MODE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define SFMP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define SFMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sfmp_pkg.sv */
package sfmp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_CLAUSE,
        PH_WHO,
        PH_MODE,
        PH_ENDED,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_PLUS
    } t_oper;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_WHO     = 2'd1;
    localparam logic [1:0] ERR_OPER    = 2'd2;
    localparam logic [1:0] ERR_GARBAGE = 2'd3;

    localparam logic [2:0] WHO_U   = 3'b001;
    localparam logic [2:0] WHO_G   = 3'b010;
    localparam logic [2:0] WHO_O   = 3'b100;
    localparam logic [2:0] WHO_ALL = 3'b111;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [11:0] UMASK_RESET = 12'o022;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  who;
        t_oper       oper;
        logic [11:0] mode;
        logic        prefix;
        logic [1:0]  err;
    } t_parse_state;

    typedef struct packed {
        logic [1:0]  err;
        logic        prefix;
        logic [11:0] mode;
    } t_result;

    localparam t_parse_state PARSE_IDLE =
        '{PH_START, 3'd0, OP_CLEAR, 12'd0, 1'b0, ERR_NONE};

endpackage

/* rtl/symbolic_file_mode_parser_unit.sv */
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: char_code[7:0]; tlast: last
// m_axis    out        tdata: mode_bits[11:0], minus_prefix, error_code[1:0], pad
// cfg       in         i_cfg_data: umask[11:0]
//
// One item per cycle while s_axis is not stalled: each character is registered, then
// stepped through the parser state; the item marked last loads the result register.
// The last item is registered first and loads the result register when it advances.
// Synchronous active-low reset clears the parse state and sets umask to 022 octal.
// s_axis stalls only when a last item waits while an untaken result is held.
module symbolic_file_mode_parser_unit
    import sfmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // mode_bits[11:0], minus_prefix, error_code[1:0], 0
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_result;
    logic [11:0]  r_umask;
    logic         r_out_valid;
    t_result      r_out;
    logic         advance;

    sfmp_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_umask  (r_umask),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Only a last item needs room in the result register.
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.err, r_out.prefix, r_out.mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= PARSE_IDLE;
            r_umask     <= UMASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_umask <= i_cfg_data;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && r_in_last) begin
            r_out <= n_result;
        end
    end

endmodule

/* rtl/sfmp_step.sv */
module sfmp_step
    import sfmp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char,
    input  logic         i_last,
    input  logic [11:0]  i_umask,
    output t_parse_state o_state,
    output t_result      o_result
);

    logic         is_oper;
    logic         is_who;
    logic [2:0]   who_bits;
    t_oper        oper_code;
    logic [11:0]  perm_bits;
    logic         perm_ok;
    logic [2:0]   w;
    t_parse_state s;

    always_comb begin
        is_oper = (i_char == CH_MINUS) || (i_char == CH_EQUAL) || (i_char == CH_PLUS);
        is_who  = (i_char == CH_U) || (i_char == CH_G) || (i_char == CH_O) || (i_char == CH_A);

        case (i_char)
            CH_U:    who_bits = WHO_U;
            CH_G:    who_bits = WHO_G;
            CH_O:    who_bits = WHO_O;
            default: who_bits = WHO_ALL;
        endcase

        case (i_char)
            CH_MINUS: oper_code = OP_CLEAR;
            CH_EQUAL: oper_code = OP_SET;
            default:  oper_code = OP_PLUS;
        endcase

        // Permission bits in octal layout: suid sgid sticky, then rwx per class.
        w         = i_state.who;
        perm_ok   = 1'b1;
        perm_bits = 12'd0;
        case (i_char)
            CH_R:    perm_bits = {3'b000, w[0], 2'b00, w[1], 2'b00, w[2], 2'b00};
            CH_W:    perm_bits = {4'b0000, w[0], 2'b00, w[1], 2'b00, w[2], 1'b0};
            CH_X:    perm_bits = {5'b00000, w[0], 2'b00, w[1], 2'b00, w[2]};
            CH_S:    perm_bits = {w[0], w[1], 10'd0};
            CH_T:    perm_bits = 12'o1000;
            default: perm_ok = 1'b0;
        endcase

        s = i_state;
        case (i_state.phase)
            PH_START, PH_CLAUSE: begin
                if (i_char == CH_NUL) begin
                    s.phase = PH_ENDED;
                end else if (i_state.phase == PH_START && i_char == CH_MINUS) begin
                    s.prefix = 1'b1;
                    s.phase  = PH_CLAUSE;
                end else if (is_oper) begin
                    s.who   = WHO_ALL;
                    s.oper  = oper_code;
                    s.phase = PH_MODE;
                end else if (is_who) begin
                    s.who   = who_bits;
                    s.phase = PH_WHO;
                end else begin
                    s.err   = ERR_WHO;
                    s.phase = PH_ERROR;
                end
            end
            PH_WHO: begin
                if (is_who) begin
                    s.who = i_state.who | who_bits;
                end else if (is_oper) begin
                    s.oper  = oper_code;
                    s.phase = PH_MODE;
                end else begin
                    s.err   = ERR_OPER;
                    s.phase = PH_ERROR;
                end
            end
            PH_MODE: begin
                if (i_char == CH_NUL) begin
                    s.phase = PH_ENDED;
                end else if (i_char == CH_COMMA) begin
                    s.phase = PH_CLAUSE;
                end else if (perm_ok) begin
                    case (i_state.oper)
                        OP_CLEAR: s.mode = i_state.mode & ~perm_bits;
                        OP_PLUS:  s.mode = i_state.mode | (perm_bits & ~i_umask);
                        default:  s.mode = i_state.mode | perm_bits;
                    endcase
                end else begin
                    s.err   = ERR_GARBAGE;
                    s.phase = PH_ERROR;
                end
            end
            default: begin
            end
        endcase

        // A string that stops inside the who letters lacks its operator.
        if (i_last && s.phase == PH_WHO) begin
            s.err = ERR_OPER;
        end

        o_result.err    = s.err;
        o_result.prefix = s.prefix;
        o_result.mode   = (s.err != ERR_NONE) ? 12'd0 : s.mode;

        o_state = i_last ? PARSE_IDLE : s;
    end

endmodule

/* rtl/sfmp_checker.sv */
`include "symbolic_file_mode_parser_unit_macros.svh"

module sfmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    // A held result must not change while the consumer stalls.
    `SFMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // A failed parse never reports permission bits.
    `SFMP_ASSERT_IMP(a_err_zero_mode, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[14:13] == 2'd0 || m_axis_tdata[11:0] == 12'd0, "mode bits with error code")

    // With the result register empty, the input side must never stall.
    `SFMP_ASSERT_IMP(a_no_stall_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with no pending result")

    // The umask register takes a write in any cycle, and the pad bit of the result is always zero.
    `SFMP_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready && m_axis_tdata[15] == 1'b0, "config not ready or pad bit set")

endmodule

bind symbolic_file_mode_parser_unit sfmp_checker u_sfmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);

/* tb/mode_string_checker.sv */
module mode_string_checker
    import sfmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,      // char_code[7:0]
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,     // mode_bits[11:0], minus_prefix, error_code[1:0], 0
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [11:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    t_phase      phase;
    logic [2:0]  who;
    t_oper       oper;
    logic [11:0] mode_acc;
    logic        prefix;
    logic [1:0]  err;
    logic [11:0] umask_reg;
    t_result     expected_modes[$];
    t_result     want;

    function automatic logic is_oper_char(logic [7:0] c);
        return c == CH_MINUS || c == CH_EQUAL || c == CH_PLUS;
    endfunction

    function automatic logic is_who_char(logic [7:0] c);
        return c == CH_U || c == CH_G || c == CH_O || c == CH_A;
    endfunction

    function automatic logic is_perm_char(logic [7:0] c);
        return c == CH_R || c == CH_W || c == CH_X || c == CH_S || c == CH_T;
    endfunction

    function automatic logic [2:0] who_bits(logic [7:0] c);
        case (c)
            CH_U:    return WHO_U;
            CH_G:    return WHO_G;
            CH_O:    return WHO_O;
            default: return WHO_ALL;
        endcase
    endfunction

    // Bit layout: suid sgid sticky, then rwx for user, group and other.
    function automatic logic [11:0] perm_bits(logic [7:0] c, logic [2:0] w);
        case (c)
            CH_R:    return {3'b000, w[0], 2'b00, w[1], 2'b00, w[2], 2'b00};
            CH_W:    return {4'b0000, w[0], 2'b00, w[1], 2'b00, w[2], 1'b0};
            CH_X:    return {5'b00000, w[0], 2'b00, w[1], 2'b00, w[2]};
            CH_S:    return {w[0], w[1], 10'd0};
            CH_T:    return 12'o1000;
            default: return 12'd0;
        endcase
    endfunction

    task automatic clear_string();
        phase    = PH_START;
        who      = 3'd0;
        oper     = OP_CLEAR;
        mode_acc = 12'd0;
        prefix   = 1'b0;
        err      = ERR_NONE;
    endtask

    task automatic flag_error(input logic [1:0] code);
        err   = code;
        phase = PH_ERROR;
    endtask

    task automatic take_oper(input logic [7:0] c);
        if (c == CH_MINUS) begin
            oper = OP_CLEAR;
        end else if (c == CH_EQUAL) begin
            oper = OP_SET;
        end else begin
            oper = OP_PLUS;
        end
        phase = PH_MODE;
    endtask

    task automatic start_clause(input logic [7:0] c);
        if (is_oper_char(c)) begin
            who = WHO_ALL;
            take_oper(c);
        end else if (is_who_char(c)) begin
            who   = who_bits(c);
            phase = PH_WHO;
        end else begin
            flag_error(ERR_WHO);
        end
    endtask

    task automatic apply_perm(input logic [7:0] c);
        logic [11:0] b;
        b = perm_bits(c, who);
        case (oper)
            OP_CLEAR: mode_acc = mode_acc & ~b;
            OP_PLUS:  mode_acc = mode_acc | (b & ~umask_reg);
            default:  mode_acc = mode_acc | b;
        endcase
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last_flag);
        case (phase)
            PH_START: begin
                if (c == CH_NUL) begin
                    phase = PH_ENDED;
                end else if (c == CH_MINUS) begin
                    prefix = 1'b1;
                    phase  = PH_CLAUSE;
                end else begin
                    start_clause(c);
                end
            end
            PH_CLAUSE: begin
                if (c == CH_NUL) begin
                    phase = PH_ENDED;
                end else begin
                    start_clause(c);
                end
            end
            PH_WHO: begin
                if (is_who_char(c)) begin
                    who = who | who_bits(c);
                end else if (is_oper_char(c)) begin
                    take_oper(c);
                end else begin
                    flag_error(ERR_OPER);
                end
            end
            PH_MODE: begin
                if (c == CH_NUL) begin
                    phase = PH_ENDED;
                end else if (c == CH_COMMA) begin
                    phase = PH_CLAUSE;
                end else if (is_perm_char(c)) begin
                    apply_perm(c);
                end else begin
                    flag_error(ERR_GARBAGE);
                end
            end
            default: begin
            end
        endcase

        if (last_flag) begin
            // A string that stops inside the who letters never saw its operator.
            if (phase == PH_WHO) begin
                flag_error(ERR_OPER);
            end
            expected_modes.push_back('{err: err, prefix: prefix,
                                       mode: (err != ERR_NONE) ? 12'd0 : mode_acc});
            clear_string();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string();
            umask_reg = UMASK_RESET;
            expected_modes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_modes.size() == 0) begin
                    $error("result %h arrived with no expectation waiting", i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_modes.pop_front();
                    if (i_out_data[11:0] !== want.mode) begin
                        $error("mode_bits: expected %o, got %o", want.mode, i_out_data[11:0]);
                        o_fail_count++;
                    end
                    if (i_out_data[12] !== want.prefix) begin
                        $error("minus_prefix: expected %0d, got %0d",
                               want.prefix, i_out_data[12]);
                        o_fail_count++;
                    end
                    if (i_out_data[14:13] !== want.err) begin
                        $error("error_code: expected %0d, got %0d",
                               want.err, i_out_data[14:13]);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                umask_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_char, i_in_last);
            end
        end
        o_pending <= expected_modes.size();
    end

endmodule

/* tb/tb.sv */
module tb;
    import sfmp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // char_code[7:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;      // mode_bits[11:0], minus_prefix, error_code[1:0], 0
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data;

    int          fail_count;
    int          pending_results;
    int          burst_left;
    int          items_sent;
    int          rx_style;
    int          rx_window;
    logic [7:0]  mode_text[$];

    always #2 i_clk = ~i_clk;

    symbolic_file_mode_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    mode_string_checker watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_char    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // The result side switches between stall styles over windows of random length.
    always @(posedge i_clk) begin
        if (rx_window <= 0) begin
            rx_style  = $urandom_range(0, 3);
            rx_window = $urandom_range(8, 60);
        end
        rx_window--;
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rx_window % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    function automatic logic [7:0] who_letter();
        case ($urandom_range(0, 3))
            0:       return CH_U;
            1:       return CH_G;
            2:       return CH_O;
            default: return CH_A;
        endcase
    endfunction

    function automatic logic [7:0] oper_letter();
        case ($urandom_range(0, 2))
            0:       return CH_MINUS;
            1:       return CH_EQUAL;
            default: return CH_PLUS;
        endcase
    endfunction

    function automatic logic [7:0] perm_letter();
        case ($urandom_range(0, 4))
            0:       return CH_R;
            1:       return CH_W;
            2:       return CH_X;
            3:       return CH_S;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] any_symbol();
        case ($urandom_range(0, 4))
            0:       return CH_NUL;
            1:       return CH_COMMA;
            2:       return who_letter();
            3:       return oper_letter();
            default: return perm_letter();
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : any_symbol();
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last_flag);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last_flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_mode_text();
        foreach (mode_text[i]) begin
            send_char(mode_text[i], i == mode_text.size() - 1);
        end
        items_sent += mode_text.size();
    endtask

    // Called right after a handshake, so lowering tvalid here is the only update
    // it gets in that step.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_umask(input logic [11:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed clauses with random content; some noise and corrupted strings.
    task automatic build_mode_text();
        int n_clauses;
        int pos;
        mode_text.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) mode_text.push_back(noise_char());
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                mode_text.push_back(CH_MINUS);
            end
            n_clauses = $urandom_range(1, 3);
            for (int k = 0; k < n_clauses; k++) begin
                if (k > 0) begin
                    mode_text.push_back(CH_COMMA);
                end
                repeat ($urandom_range(0, 3)) mode_text.push_back(who_letter());
                mode_text.push_back(oper_letter());
                repeat ($urandom_range(0, 4)) mode_text.push_back(perm_letter());
            end
            if ($urandom_range(0, 9) == 0) begin
                mode_text.push_back(CH_COMMA);
            end
            if ($urandom_range(0, 6) == 0) begin
                pos = $urandom_range(0, mode_text.size() - 1);
                mode_text[pos] = noise_char();
            end
            if ($urandom_range(0, 9) == 0) begin
                mode_text.push_back(CH_NUL);
                mode_text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [11:0] umask_plan[5];
        int          phase_start;
        umask_plan = '{12'h000, 12'hFFF, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), UMASK_RESET};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 12'd0;
        burst_left = 0;
        items_sent = 0;
        rx_window  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty string, and a string of only the minus prefix.
        mode_text = '{CH_NUL};
        send_mode_text();
        mode_text = '{CH_MINUS};
        send_mode_text();
        // A NUL right after a who letter is a missing operator; the rest is ignored.
        mode_text = '{CH_U, CH_NUL, CH_X};
        send_mode_text();
        // Operator with no who letters, suid/sgid and sticky, trailing comma.
        mode_text = '{CH_PLUS, CH_S, CH_T, CH_COMMA};
        send_mode_text();
        // String ends after who letters.
        mode_text = '{CH_G};
        send_mode_text();
        mode_text = '{CH_EQUAL, CH_X, CH_NUL, 8'hFF};
        send_mode_text();
        mode_text = '{CH_A, CH_MINUS, CH_R};
        send_mode_text();
        // Bad first character, and a high character where an operator belongs.
        mode_text = '{8'hFF};
        send_mode_text();
        mode_text = '{CH_U, 8'h80};
        send_mode_text();
        // Garbage after the operator; characters after the error are ignored.
        mode_text = '{CH_PLUS, 8'h71, CH_COMMA};
        send_mode_text();

        foreach (umask_plan[p]) begin
            set_umask(umask_plan[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < 100) begin
                build_mode_text();
                send_mode_text();
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
